@@ rtl/integer_to_ascii_radix_top_macros.svh @@
// assertion macros for the integer to ascii radix block
// used by the checker; expects clk and arst_n in the scope of use
`ifndef INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/itoa_pkg.sv @@
// shared constants, types and the digit glyph function for the radix converter
// no dependencies
`default_nettype none

package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;
	// dividend bits retired by the divider in each cycle
	localparam int STEP_BITS   = 8;
	localparam int RADIX_LIMIT = 16;

	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] LETTER_A   = 8'h41;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic emit_sign;
		logic emit_digit;
		logic emit_err;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic bad_base;
		logic quot_zero;
		logic almost_full;
		logic one_left;
		logic neg;
	} status_t;

	// ascii glyph for one digit value
	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = ZERO_CHAR + {4'b0000, d};
		end else begin
			g = LETTER_A + {4'b0000, d} - 8'd10;
		end
		return g;
	endfunction

endpackage

`default_nettype wire

@@ rtl/itoa_dpath.sv @@
// datapath: magnitude register, radix divider, digit stack and result registers
// depends on itoa_pkg
`default_nettype none

module itoa_dpath #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH,
	parameter int MAX_DIGITS  = itoa_pkg::MAX_DIGITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic        [4:0]             base,
	input  wire itoa_pkg::cmd_t                cmd,
	output itoa_pkg::status_t                  status,
	output logic             [7:0]             character,
	output logic                               last,
	output logic                               error
);

	localparam int DIV_CYCLES = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
	localparam int PW         = DIV_CYCLES * itoa_pkg::STEP_BITS;
	localparam int SW         = MAX_DIGITS * 4;
	localparam int NW         = $clog2(MAX_DIGITS + 1);

	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [PW-1:0]          mag_q;
	logic [PW-1:0]          mag_next;
	logic [3:0]             rem_q;
	logic [3:0]             rem_next;
	logic [4:0]             base_q;
	logic                   neg_q;
	logic [SW-1:0]          stack_q;
	logic [NW-1:0]          ndig_q;

	// magnitude of the incoming value, full range including the most negative
	assign val_u  = value;
	assign mag_in = val_u[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - val_u) : val_u;

	// restoring division, a byte of dividend per cycle while div_step is set
	always_comb begin
		logic [4:0]    r;
		logic [PW-1:0] m;
		r = {1'b0, rem_q};
		m = mag_q;
		for (int i = 0; i < itoa_pkg::STEP_BITS; i++) begin
			r = {r[3:0], m[PW-1]};
			m = {m[PW-2:0], 1'b0};
			if (r >= base_q) begin
				r    = r - base_q;
				m[0] = 1'b1;
			end
		end
		mag_next = m;
		rem_next = r[3:0];
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
		end else if (cmd.load) begin
			ndig_q <= '0;
		end else if (cmd.push) begin
			ndig_q <= ndig_q + NW'(1);
		end else if (cmd.emit_digit) begin
			ndig_q <= ndig_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= PW'(mag_in);
			rem_q  <= 4'd0;
			base_q <= base;
			neg_q  <= val_u[VALUE_WIDTH-1];
		end else if (cmd.div_step) begin
			mag_q <= mag_next;
			rem_q <= rem_next;
		end else if (cmd.push) begin
			rem_q <= 4'd0;
		end
	end

	// digit stack, least significant digit pushed first, popped last
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_q <= {stack_q[SW-5:0], rem_q};
		end else if (cmd.emit_digit) begin
			stack_q <= {4'b0000, stack_q[SW-1:4]};
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			character <= 8'd0;
			last      <= 1'b1;
			error     <= 1'b1;
		end else if (cmd.emit_sign) begin
			character <= itoa_pkg::MINUS_CHAR;
			last      <= 1'b0;
			error     <= 1'b0;
		end else if (cmd.emit_digit) begin
			character <= itoa_pkg::digit_glyph(stack_q[3:0]);
			last      <= (ndig_q == NW'(1));
			error     <= 1'b0;
		end
	end

	// status back to the controller
	assign status.bad_base    = (base < 5'd2) || (base > 5'(itoa_pkg::RADIX_LIMIT));
	assign status.quot_zero   = (mag_q == '0);
	assign status.almost_full = (ndig_q == NW'(MAX_DIGITS - 1));
	assign status.one_left    = (ndig_q == NW'(1));
	assign status.neg         = neg_q;

endmodule

`default_nettype wire

@@ rtl/itoa_ctrl.sv @@
// controller: sequences division, digit pushes and character emission
// depends on itoa_pkg
`default_nettype none

module itoa_ctrl #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   strobe,
	input  wire itoa_pkg::status_t status,
	output itoa_pkg::cmd_t         cmd
);

	localparam int DIV_CYCLES = (VALUE_WIDTH + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
	localparam int CW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_PUSH = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] step_q;
	logic          strobe_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (status.bad_base) begin
						cmd.emit_err = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == CW'(DIV_CYCLES - 1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				if (status.quot_zero || status.almost_full) begin
					state_d = status.neg ? ST_SIGN : ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				if (status.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, division step count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= cmd.emit_err | cmd.emit_sign | cmd.emit_digit;
			if (cmd.div_step && (step_q != CW'(DIV_CYCLES - 1))) begin
				step_q <= step_q + CW'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;

endmodule

`default_nettype wire

@@ rtl/integer_to_ascii_radix_top.sv @@
// top level of the integer to ascii radix converter
// depends on itoa_pkg, itoa_ctrl and itoa_dpath
//
//   channel   handshake        payload
//   input     start / busy     value, base
//   result    strobe           character, last, error
//
// for each digit the controller runs the division steps and then a push, D being the digit
// count; the characters then follow back to back (sign if negative, plus D digits)
// the divider retires eight dividend bits per cycle of division, and each digit adds a push step
// a bad base gives its single error result in the cycle after start, busy stays low
// each result is shown for one cycle on strobe; the receiver cannot stall
// reset is asynchronous, active low, and returns the controller to idle
`default_nettype none

module integer_to_ascii_radix_top #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH,
	parameter int MAX_DIGITS  = itoa_pkg::MAX_DIGITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic        [4:0]             base,
	output logic                               strobe,
	output logic             [7:0]             character,
	output logic                               last,
	output logic                               error
);

	itoa_pkg::cmd_t    cmd;
	itoa_pkg::status_t status;

	// sequencing
	itoa_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.strobe(strobe),
		.status(status),
		.cmd   (cmd)
	);

	// arithmetic and storage
	itoa_dpath #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (value),
		.base     (base),
		.cmd      (cmd),
		.status   (status),
		.character(character),
		.last     (last),
		.error    (error)
	);

endmodule

`default_nettype wire

@@ rtl/itoa_checker.sv @@
// port-level checker for the radix converter, bound to the top level
// depends on itoa_pkg and integer_to_ascii_radix_top_macros.svh
`default_nettype none

`include "integer_to_ascii_radix_top_macros.svh"

module itoa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [4:0] base,
	input wire logic       strobe,
	input wire logic [7:0] character,
	input wire logic       last,
	input wire logic       error
);

	// an error result is a lone, empty character
	`ITOA_ASSERT_NOW(a_err_shape, strobe && error, last && (character == 8'd0), "bad error result")

	// a bad base, started while idle, is answered with an error result
	`ITOA_ASSERT_NEXT(a_bad_base, start && !busy && ((base < 5'd2) || (base > 5'(itoa_pkg::RADIX_LIMIT))), strobe && error, "bad base not flagged")

	// characters of one item come back to back
	`ITOA_ASSERT_NEXT(a_no_gap, strobe && !last, strobe, "gap inside a text")

	// the block stays busy while a text is unfinished
	`ITOA_ASSERT_NOW(a_busy_mid, strobe && !last, busy, "idle inside a text")

endmodule

bind integer_to_ascii_radix_top itoa_checker u_itoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.base     (base),
	.strobe   (strobe),
	.character(character),
	.last     (last),
	.error    (error)
);

`default_nettype wire
